// ----- hw/rtl/alurf_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// alurf_pkg: shared types and constants for the ALU register file block
// Holds the operation codes, the decoded micro-op that travels from the
// front end through the queue to the back end, and the status bundles.
// ============================================================================

package alurf_pkg;

   // Field widths fixed by the instruction format.
   localparam int WORD_W    = 32;
   localparam int IDX_W     = 3;
   localparam int OP_W      = 3;
   localparam int SHAMT_W   = 5;

   // Default register count and depth of the queue between front and back.
   localparam int REG_COUNT_DEFAULT = 8;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QCOUNT_W          = $clog2(QUEUE_DEPTH + 1);

   // Operation codes as they arrive on the request channel.
   typedef enum logic [OP_W-1:0] {
      OP_MOV = 3'd0,
      OP_LSL = 3'd1,
      OP_LSR = 3'd2,
      OP_ADD = 3'd3,
      OP_SUB = 3'd4,
      OP_AND = 3'd5,
      OP_ORR = 3'd6,
      OP_XOR = 3'd7
   } alu_op_type;

   // Condition flags.
   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } nzcv_type;

   // Decoded instruction, classified by the front end.
   typedef struct packed {
      alu_op_type               op;
      logic [IDX_W-1:0]         dest;
      logic [IDX_W-1:0]         src1;
      logic [IDX_W-1:0]         src2;
      logic                     dest_ok;
      logic                     src1_ok;
      logic                     src2_ok;
      logic [WORD_W-1:0]        imm;
      logic [SHAMT_W-1:0]       shamt;
      logic                     upd_nz;
      logic                     upd_c;
      logic                     upd_v;
   } uop_type;

   // Queue occupancy, seen by the top level.
   typedef struct packed {
      logic                     full;
      logic                     empty;
      logic [QCOUNT_W-1:0]      count;
   } queue_status_type;

   // Execute stage status, seen by the top level.
   typedef struct packed {
      logic                     ex_fire;
      alu_op_type               ex_op;
      nzcv_type                 flags;
   } back_status_type;

endpackage

// ----- hw/rtl/alurf_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// alurf_front: request intake and instruction classification
// Accepts request beats while the queue has room, checks register indexes
// against the register count and marks which flags the instruction updates.
// ============================================================================

module alurf_front #(
   parameter int RegCount = alurf_pkg::REG_COUNT_DEFAULT
) (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [alurf_pkg::OP_W-1:0]        req_action,
   input  logic [alurf_pkg::IDX_W-1:0]       req_dest_reg,
   input  logic [alurf_pkg::IDX_W-1:0]       req_first_src,
   input  logic [alurf_pkg::IDX_W-1:0]       req_second_src,
   input  logic [alurf_pkg::WORD_W-1:0]      req_immediate,
   input  logic                              q_full,
   output logic                              push,
   output alurf_pkg::uop_type                push_uop
);

   alurf_pkg::alu_op_type op;
   logic                  shift_nonzero;

   // A beat is taken whenever the queue can hold it.
   assign req_ready = ~q_full;
   assign push      = req_valid & ~q_full;

   assign op            = alurf_pkg::alu_op_type'(req_action);
   assign shift_nonzero = (req_immediate[alurf_pkg::SHAMT_W-1:0] != '0);

   // Build the micro-op and decide which flags it writes.
   always_comb begin
      push_uop         = '0;
      push_uop.op      = op;
      push_uop.dest    = req_dest_reg;
      push_uop.src1    = req_first_src;
      push_uop.src2    = req_second_src;
      push_uop.dest_ok = (int'(req_dest_reg) < RegCount);
      push_uop.src1_ok = (int'(req_first_src) < RegCount);
      push_uop.src2_ok = (int'(req_second_src) < RegCount);
      push_uop.imm     = req_immediate;
      push_uop.shamt   = req_immediate[alurf_pkg::SHAMT_W-1:0];
      case (op)
         alurf_pkg::OP_LSL, alurf_pkg::OP_LSR: begin
            push_uop.upd_nz = 1'b1;
            // A shift by zero keeps the carry.
            push_uop.upd_c  = shift_nonzero;
         end
         alurf_pkg::OP_ADD, alurf_pkg::OP_SUB: begin
            push_uop.upd_nz = 1'b1;
            push_uop.upd_c  = 1'b1;
            push_uop.upd_v  = 1'b1;
         end
         alurf_pkg::OP_AND: begin
            push_uop.upd_nz = 1'b1;
         end
         default: begin
            push_uop.upd_nz = 1'b0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/alurf_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// alurf_queue: short micro-op queue between front end and back end
// A small circular buffer that lets intake and execution stall independently.
// ============================================================================

module alurf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  alurf_pkg::uop_type            push_uop,
   input  logic                          pop,
   output alurf_pkg::uop_type            head_uop,
   output alurf_pkg::queue_status_type   status
);

   localparam int Depth = alurf_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = alurf_pkg::QCOUNT_W;

   alurf_pkg::uop_type  entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_uop;
      end
   end

   assign head_uop     = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);

endmodule

// ----- hw/rtl/alurf_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// alurf_back: register read, execute and result register
// Reads both sources from the register file into operand registers, executes one
// micro-op per cycle while the output register is free or draining, writes the
// destination and flags, and holds the result beat in that register until taken.
// ============================================================================

module alurf_back #(
   parameter int RegCount = alurf_pkg::REG_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  alurf_pkg::uop_type                head_uop,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [alurf_pkg::IDX_W-1:0]       rsp_written_reg,
   output logic [alurf_pkg::WORD_W-1:0]      rsp_written_value,
   output logic                              rsp_flag_negative,
   output logic                              rsp_flag_zero,
   output logic                              rsp_flag_carry,
   output logic                              rsp_flag_overflow,
   output alurf_pkg::back_status_type        status
);

   localparam int AddrW = (RegCount > 1) ? $clog2(RegCount) : 1;
   localparam int W     = alurf_pkg::WORD_W;
   localparam int SW    = alurf_pkg::SHAMT_W;

   // Register file storage with one valid bit per entry.
   logic [W-1:0]           rf_ff [RegCount];
   logic [RegCount-1:0]    rf_valid_ff;

   // Execute stage.
   logic                   ex_valid_ff, ex_valid_in;
   alurf_pkg::uop_type     ex_uop_ff;
   logic [W-1:0]           opa_ff, opb_ff;
   alurf_pkg::nzcv_type    flags_ff, flags_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [alurf_pkg::IDX_W-1:0] rsp_reg_ff;
   logic [W-1:0]           rsp_value_ff;
   alurf_pkg::nzcv_type    rsp_flags_ff;

   logic                   ex_fire;
   logic                   wr_en;
   logic [AddrW-1:0]       wr_addr, ra_addr, rb_addr;
   logic                   fwd_a, fwd_b;
   logic [W-1:0]           result;
   logic                   carry_calc;
   logic                   ovf_calc;
   logic [W:0]             sum_wide, diff_wide;
   logic [SW-1:0]          lsl_cbit, lsr_cbit;

   // Stage handshakes: execute fires when the output register is free or
   // draining; a new micro-op is read when the execute stage will be free.
   assign ex_fire      = ex_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign pop          = q_valid & (~ex_valid_ff | ex_fire);
   assign ex_valid_in  = pop | (ex_valid_ff & ~ex_fire);
   assign rsp_valid_in = ex_fire | (rsp_valid_ff & ~rsp_ready);

   // Register file addressing and same-cycle write forwarding.
   assign wr_en   = ex_fire & ex_uop_ff.dest_ok;
   assign wr_addr = AddrW'(ex_uop_ff.dest);
   assign ra_addr = AddrW'(head_uop.src1);
   assign rb_addr = AddrW'(head_uop.src2);
   assign fwd_a   = wr_en & (wr_addr == ra_addr);
   assign fwd_b   = wr_en & (wr_addr == rb_addr);

   // Adder, subtractor and shift carry bit positions.
   assign sum_wide  = {1'b0, opa_ff} + {1'b0, opb_ff};
   assign diff_wide = {1'b0, opa_ff} - {1'b0, opb_ff};
   assign lsl_cbit  = SW'(6'd32 - {1'b0, ex_uop_ff.shamt});
   assign lsr_cbit  = ex_uop_ff.shamt - SW'(1);

   // Execute the operation.
   always_comb begin
      result     = '0;
      carry_calc = 1'b0;
      ovf_calc   = 1'b0;
      case (ex_uop_ff.op)
         alurf_pkg::OP_MOV: begin
            result = ex_uop_ff.imm;
         end
         alurf_pkg::OP_LSL: begin
            result     = opa_ff << ex_uop_ff.shamt;
            carry_calc = opa_ff[lsl_cbit];
         end
         alurf_pkg::OP_LSR: begin
            result     = opa_ff >> ex_uop_ff.shamt;
            carry_calc = opa_ff[lsr_cbit];
         end
         alurf_pkg::OP_ADD: begin
            result     = sum_wide[W-1:0];
            carry_calc = sum_wide[W];
            ovf_calc   = ~(opa_ff[W-1] ^ opb_ff[W-1]) & (opa_ff[W-1] ^ result[W-1]);
         end
         alurf_pkg::OP_SUB: begin
            result     = diff_wide[W-1:0];
            // Carry means no borrow.
            carry_calc = ~diff_wide[W];
            ovf_calc   = (opa_ff[W-1] ^ opb_ff[W-1]) & (opa_ff[W-1] ^ result[W-1]);
         end
         alurf_pkg::OP_AND: begin
            result = opa_ff & opb_ff;
         end
         alurf_pkg::OP_ORR: begin
            result = opa_ff | opb_ff;
         end
         default: begin
            result = opa_ff ^ opb_ff;
         end
      endcase
   end

   // Flag update under the classification from the front end.
   always_comb begin
      flags_in = flags_ff;
      if (ex_uop_ff.upd_nz) begin
         flags_in.n = result[W-1];
         flags_in.z = (result == '0);
      end
      if (ex_uop_ff.upd_c) begin
         flags_in.c = carry_calc;
      end
      if (ex_uop_ff.upd_v) begin
         flags_in.v = ovf_calc;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
         rf_valid_ff  <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ex_fire) begin
            flags_ff <= flags_in;
         end
         if (wr_en) begin
            rf_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Register file write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_ff[wr_addr] <= result;
      end
   end

   // Register file read ports into the operand registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         ex_uop_ff <= head_uop;
         if (!head_uop.src1_ok) begin
            opa_ff <= '0;
         end else if (fwd_a) begin
            opa_ff <= result;
         end else if (!rf_valid_ff[ra_addr]) begin
            opa_ff <= '0;
         end else begin
            opa_ff <= rf_ff[ra_addr];
         end
         if (!head_uop.src2_ok) begin
            opb_ff <= '0;
         end else if (fwd_b) begin
            opb_ff <= result;
         end else if (!rf_valid_ff[rb_addr]) begin
            opb_ff <= '0;
         end else begin
            opb_ff <= rf_ff[rb_addr];
         end
      end
   end

   // Result beat payload.
   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_reg_ff   <= ex_uop_ff.dest;
         rsp_value_ff <= result;
         rsp_flags_ff <= flags_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_written_reg   = rsp_reg_ff;
   assign rsp_written_value = rsp_value_ff;
   assign rsp_flag_negative = rsp_flags_ff.n;
   assign rsp_flag_zero     = rsp_flags_ff.z;
   assign rsp_flag_carry    = rsp_flags_ff.c;
   assign rsp_flag_overflow = rsp_flags_ff.v;

   assign status.ex_fire = ex_fire;
   assign status.ex_op   = ex_uop_ff.op;
   assign status.flags   = flags_ff;

endmodule

// ----- hw/rtl/alu_register_file_with_flags.sv -----
`timescale 1ns / 1ps
// A request beat accepted into the queue goes through register read into the
// operand registers, then execute into the output register. Throughput: one
// instruction per cycle while result beats are taken, set by the execute stage
// and the write-forwarded register file read. Reset marks all registers invalid
// (read as zero) and clears the flags, the queue and both pipeline stages.
// ============================================================================
// alu_register_file_with_flags: ALU with register file and NZCV flags
// A front end classifies instructions into a short queue; a back end reads
// the sources, executes, writes the destination and flags, and returns one
// result beat per instruction.
// ============================================================================

module alu_register_file_with_flags #(
   parameter int RegCount = alurf_pkg::REG_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [alurf_pkg::OP_W-1:0]        req_action,
   input  logic [alurf_pkg::IDX_W-1:0]       req_dest_reg,
   input  logic [alurf_pkg::IDX_W-1:0]       req_first_src,
   input  logic [alurf_pkg::IDX_W-1:0]       req_second_src,
   input  logic [alurf_pkg::WORD_W-1:0]      req_immediate,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [alurf_pkg::IDX_W-1:0]       rsp_written_reg,
   output logic [alurf_pkg::WORD_W-1:0]      rsp_written_value,
   output logic                              rsp_flag_negative,
   output logic                              rsp_flag_zero,
   output logic                              rsp_flag_carry,
   output logic                              rsp_flag_overflow
);

   logic                          push;
   logic                          pop;
   alurf_pkg::uop_type            push_uop;
   alurf_pkg::uop_type            head_uop;
   alurf_pkg::queue_status_type   q_status;
   alurf_pkg::back_status_type    back_status;

   // Intake and classification.
   alurf_front #(
      .RegCount (RegCount)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_dest_reg   (req_dest_reg),
      .req_first_src  (req_first_src),
      .req_second_src (req_second_src),
      .req_immediate  (req_immediate),
      .q_full         (q_status.full),
      .push           (push),
      .push_uop       (push_uop)
   );

   // Decoupling queue.
   alurf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_uop (push_uop),
      .pop      (pop),
      .head_uop (head_uop),
      .status   (q_status)
   );

   // Register read, execute and result register.
   alurf_back #(
      .RegCount (RegCount)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (~q_status.empty),
      .head_uop          (head_uop),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_written_reg   (rsp_written_reg),
      .rsp_written_value (rsp_written_value),
      .rsp_flag_negative (rsp_flag_negative),
      .rsp_flag_zero     (rsp_flag_zero),
      .rsp_flag_carry    (rsp_flag_carry),
      .rsp_flag_overflow (rsp_flag_overflow),
      .status            (back_status)
   );

`ifndef SYNTHESIS
   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= alurf_pkg::QCOUNT_W'(alurf_pkg::QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from an empty queue");

   // MOV, ORR and XOR leave the flags unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (back_status.ex_fire && (back_status.ex_op == alurf_pkg::OP_MOV ||
                               back_status.ex_op == alurf_pkg::OP_ORR ||
                               back_status.ex_op == alurf_pkg::OP_XOR))
      |=> (back_status.flags == $past(back_status.flags)))
      else $error("flags changed by a flag-preserving operation");

   // An executed instruction always lands in the output register.
   assert property (@(posedge clock) disable iff (reset)
      back_status.ex_fire |=> rsp_valid)
      else $error("executed instruction produced no result beat");
`endif

endmodule

// ----- tb/alu_register_file_with_flags_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// alu_register_file_with_flags_tb: self-checking bench for the NZCV ALU
// A queue of decoded instructions feeds a clocked driver. A clocked monitor
// mirrors the register file and the flags, predicts every result beat and
// compares it field by field. Both channels idle at random. One long
// response hold-off fills the pipeline, and drain points empty it.
// ============================================================================

module alu_register_file_with_flags_tb;

   localparam int WORD_W        = alurf_pkg::WORD_W;
   localparam int IDX_W         = alurf_pkg::IDX_W;
   localparam int OP_W          = alurf_pkg::OP_W;
   localparam int SHAMT_W       = alurf_pkg::SHAMT_W;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_INSTRS = 1500;
   localparam int HOLD_START    = 400;
   localparam int HOLD_CYCLES   = 80;
   localparam int CALM_START    = 900;
   localparam int CALM_END      = 1300;
   localparam int IDLE_PERCENT  = 12;

   // One decoded instruction waiting to be offered.
   typedef struct {
      alurf_pkg::alu_op_type op;
      logic [IDX_W-1:0]    dest;
      logic [IDX_W-1:0]    src1;
      logic [IDX_W-1:0]    src2;
      logic [WORD_W-1:0]   imm;
      bit                  drain_first;
   } instr_item_type;

   // Register write-back and flags that one instruction must report.
   typedef struct {
      logic [IDX_W-1:0]    written_reg;
      logic [WORD_W-1:0]   written_value;
      alurf_pkg::nzcv_type flags;
   } writeback_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_action = '0;
   logic [IDX_W-1:0]    req_dest_reg = '0;
   logic [IDX_W-1:0]    req_first_src = '0;
   logic [IDX_W-1:0]    req_second_src = '0;
   logic [WORD_W-1:0]   req_immediate = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [IDX_W-1:0]    rsp_written_reg;
   logic [WORD_W-1:0]   rsp_written_value;
   logic                rsp_flag_negative;
   logic                rsp_flag_zero;
   logic                rsp_flag_carry;
   logic                rsp_flag_overflow;

   instr_item_type      instr_backlog[$];
   writeback_type       expected_writebacks[$];
   logic [WORD_W-1:0]   arch_regs[alurf_pkg::REG_COUNT_DEFAULT];
   alurf_pkg::nzcv_type arch_flags;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  hold_left = 0;
   bit                  hold_done = 1'b0;
   bit                  req_beat = 1'b0;
   bit                  drain_next = 1'b0;

   alu_register_file_with_flags u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_dest_reg      (req_dest_reg),
      .req_first_src     (req_first_src),
      .req_second_src    (req_second_src),
      .req_immediate     (req_immediate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_written_reg   (rsp_written_reg),
      .rsp_written_value (rsp_written_value),
      .rsp_flag_negative (rsp_flag_negative),
      .rsp_flag_zero     (rsp_flag_zero),
      .rsp_flag_carry    (rsp_flag_carry),
      .rsp_flag_overflow (rsp_flag_overflow)
   );

   // Free-running clock with a 2 ns period.
   always #1 clock = ~clock;

   // Cycle count used for the idle windows and the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Counts one mismatch and prints a line for it while fewer than 100 have been seen.
   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      if (mismatch_count < 100) begin
         $display("MISMATCH at cycle %0d: %s got %h, expected %h",
                  cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   // Queues one instruction; a pending drain request attaches to it.
   task automatic add_instr(input alurf_pkg::alu_op_type op, input logic [IDX_W-1:0] dest,
                            input logic [IDX_W-1:0] src1, input logic [IDX_W-1:0] src2,
                            input logic [WORD_W-1:0] imm);
      instr_item_type item;
      item.op          = op;
      item.dest        = dest;
      item.src1        = src1;
      item.src2        = src2;
      item.imm         = imm;
      item.drain_first = drain_next;
      drain_next       = 1'b0;
      instr_backlog.push_back(item);
   endtask

   // Random register index.
   function automatic logic [IDX_W-1:0] pick_reg();
      return IDX_W'($urandom_range(7));
   endfunction

   // Word with a bias toward the sign and carry boundaries.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // Executes one instruction on the mirrored state and returns its write-back.
   // Sources are read before the destination is written.
   function automatic writeback_type alu_execute(input alurf_pkg::alu_op_type op,
                                                 input logic [IDX_W-1:0] dest,
                                                 input logic [IDX_W-1:0] src1,
                                                 input logic [IDX_W-1:0] src2,
                                                 input logic [WORD_W-1:0] imm);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] r;
      logic [WORD_W-1:0] ovf;
      logic [WORD_W:0]   wide;
      int                n;
      writeback_type     wb;
      a = arch_regs[src1];
      b = arch_regs[src2];
      n = int'(imm[SHAMT_W-1:0]);
      r = '0;
      case (op)
         alurf_pkg::OP_MOV: r = imm;
         alurf_pkg::OP_LSL: begin
            // A shift by zero passes the source through and keeps C.
            r = a << n;
            if (n != 0) arch_flags.c = a[WORD_W - n];
         end
         alurf_pkg::OP_LSR: begin
            r = a >> n;
            if (n != 0) arch_flags.c = a[n - 1];
         end
         alurf_pkg::OP_ADD: begin
            wide         = {1'b0, a} + {1'b0, b};
            r            = wide[WORD_W-1:0];
            ovf          = ~(a ^ b) & (a ^ r);
            arch_flags.c = wide[WORD_W];
            arch_flags.v = ovf[WORD_W-1];
         end
         alurf_pkg::OP_SUB: begin
            // Carry means no borrow.
            r            = a - b;
            ovf          = (a ^ b) & (a ^ r);
            arch_flags.c = (a >= b);
            arch_flags.v = ovf[WORD_W-1];
         end
         alurf_pkg::OP_AND: r = a & b;
         alurf_pkg::OP_ORR: r = a | b;
         default: r = a ^ b;
      endcase
      // MOV, ORR and XOR leave the flags alone.
      if (op != alurf_pkg::OP_MOV && op != alurf_pkg::OP_ORR && op != alurf_pkg::OP_XOR) begin
         arch_flags.n = r[WORD_W-1];
         arch_flags.z = (r == '0);
      end
      arch_regs[dest]  = r;
      wb.written_reg   = dest;
      wb.written_value = r;
      wb.flags         = arch_flags;
      return wb;
   endfunction

   // Request driver: offers the next queued instruction unless idling or
   // waiting for the pipeline to drain. Valid holds until the beat is taken.
   always @(negedge clock) begin
      instr_item_type item;
      bit             calm;
      bit             blocked;
      calm = (cycle_count >= CALM_START && cycle_count < CALM_END);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         blocked = (instr_backlog.size() == 0) ||
                   (instr_backlog[0].drain_first && expected_writebacks.size() != 0) ||
                   (!calm && $urandom_range(99) < IDLE_PERCENT);
         if (blocked) begin
            req_valid <= 1'b0;
         end else begin
            item = instr_backlog.pop_front();
            req_valid      <= 1'b1;
            req_action     <= item.op;
            req_dest_reg   <= item.dest;
            req_first_src  <= item.src1;
            req_second_src <= item.src2;
            req_immediate  <= item.imm;
         end
      end
   end

   // One long response hold-off while requests keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && cycle_count >= HOLD_START) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response ready: random stalls outside the calm window, held low during the hold-off.
   always @(negedge clock) begin
      bit calm;
      calm = (cycle_count >= CALM_START && cycle_count < CALM_END);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor: checks each result beat, then predicts each accepted request.
   always @(posedge clock) begin
      writeback_type want;
      if (reset) begin
         req_beat = 1'b0;
         foreach (arch_regs[i]) arch_regs[i] = '0;
         arch_flags = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_writebacks.size() == 0) begin
               report_mismatch("result beat with nothing expected, value",
                               rsp_written_value, '0);
            end else begin
               want = expected_writebacks.pop_front();
               if (rsp_written_reg !== want.written_reg)
                  report_mismatch("written_reg", WORD_W'(rsp_written_reg),
                                  WORD_W'(want.written_reg));
               if (rsp_written_value !== want.written_value)
                  report_mismatch("written_value", rsp_written_value, want.written_value);
               if (rsp_flag_negative !== want.flags.n)
                  report_mismatch("flag_negative", WORD_W'(rsp_flag_negative),
                                  WORD_W'(want.flags.n));
               if (rsp_flag_zero !== want.flags.z)
                  report_mismatch("flag_zero", WORD_W'(rsp_flag_zero),
                                  WORD_W'(want.flags.z));
               if (rsp_flag_carry !== want.flags.c)
                  report_mismatch("flag_carry", WORD_W'(rsp_flag_carry),
                                  WORD_W'(want.flags.c));
               if (rsp_flag_overflow !== want.flags.v)
                  report_mismatch("flag_overflow", WORD_W'(rsp_flag_overflow),
                                  WORD_W'(want.flags.v));
            end
         end
         req_beat = req_valid && req_ready;
         if (req_beat) begin
            expected_writebacks.push_back(alu_execute(alurf_pkg::alu_op_type'(req_action),
                                                      req_dest_reg, req_first_src,
                                                      req_second_src, req_immediate));
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int          roll;
      logic [WORD_W-1:0] imm;

      // Directed: boundary values, every operation and the flag corner cases.
      add_instr(alurf_pkg::OP_MOV, 3'd0, 3'd5, 3'd6, 32'hFFFF_FFFF);
      add_instr(alurf_pkg::OP_MOV, 3'd1, 3'd0, 3'd0, 32'h8000_0000);
      add_instr(alurf_pkg::OP_MOV, 3'd2, 3'd7, 3'd7, 32'h7FFF_FFFF);
      add_instr(alurf_pkg::OP_MOV, 3'd3, 3'd1, 3'd2, 32'h0000_0001);
      add_instr(alurf_pkg::OP_MOV, 3'd7, 3'd3, 3'd4, 32'h0000_0000);
      add_instr(alurf_pkg::OP_ADD, 3'd4, 3'd0, 3'd3, 32'hFFFF_FFFF);  // carry out, zero result
      add_instr(alurf_pkg::OP_ADD, 3'd5, 3'd2, 3'd3, 32'h0);          // signed overflow
      add_instr(alurf_pkg::OP_ADD, 3'd6, 3'd1, 3'd1, 32'h0);          // carry and overflow
      add_instr(alurf_pkg::OP_SUB, 3'd4, 3'd3, 3'd3, 32'h0);          // equal operands
      add_instr(alurf_pkg::OP_SUB, 3'd5, 3'd7, 3'd3, 32'h0);          // borrow
      add_instr(alurf_pkg::OP_SUB, 3'd6, 3'd1, 3'd3, 32'h0);          // signed overflow
      add_instr(alurf_pkg::OP_LSL, 3'd4, 3'd0, 3'd1, 32'hFFFF_FFE0);  // shift by zero keeps C
      add_instr(alurf_pkg::OP_LSL, 3'd4, 3'd3, 3'd2, 32'h0000_001F);
      add_instr(alurf_pkg::OP_LSL, 3'd5, 3'd1, 3'd0, 32'h0000_0001);  // carry from the sign bit
      add_instr(alurf_pkg::OP_LSR, 3'd5, 3'd3, 3'd6, 32'hFFFF_FFE1);  // carry from bit zero
      add_instr(alurf_pkg::OP_LSR, 3'd6, 3'd1, 3'd0, 32'h0000_001F);
      add_instr(alurf_pkg::OP_LSR, 3'd6, 3'd0, 3'd5, 32'h0000_0000);  // shift by zero keeps C
      add_instr(alurf_pkg::OP_AND, 3'd4, 3'd1, 3'd2, 32'hFFFF_FFFF);
      add_instr(alurf_pkg::OP_AND, 3'd5, 3'd0, 3'd1, 32'h0);
      add_instr(alurf_pkg::OP_ORR, 3'd6, 3'd3, 3'd1, 32'h0);
      add_instr(alurf_pkg::OP_XOR, 3'd7, 3'd0, 3'd0, 32'h0);
      add_instr(alurf_pkg::OP_ADD, 3'd0, 3'd0, 3'd0, 32'h0);          // sources equal destination
      add_instr(alurf_pkg::OP_XOR, 3'd2, 3'd2, 3'd0, 32'h0);
      drain_next = 1'b1;
      add_instr(alurf_pkg::OP_SUB, 3'd1, 3'd2, 3'd1, 32'h0);

      // Random: loads keep the registers varied, shifts and ALU ops mix freely.
      for (int k = 0; k < RANDOM_INSTRS; k++) begin
         if (k % 250 == 249) drain_next = 1'b1;
         roll = $urandom_range(99);
         if (roll < 22) begin
            imm = pick_word();
            add_instr(alurf_pkg::OP_MOV, pick_reg(), pick_reg(), pick_reg(), imm);
         end else if (roll < 40) begin
            imm = $urandom;
            if ($urandom_range(3) == 0) begin
               imm[SHAMT_W-1:0] = ($urandom_range(1) != 0) ? 5'd31 : 5'd0;
            end
            add_instr(($urandom_range(1) != 0) ? alurf_pkg::OP_LSL : alurf_pkg::OP_LSR,
                      pick_reg(), pick_reg(), pick_reg(), imm);
         end else begin
            add_instr(alurf_pkg::alu_op_type'($urandom_range(alurf_pkg::OP_ADD,
                                                             alurf_pkg::OP_XOR)),
                      pick_reg(), pick_reg(), pick_reg(), $urandom);
         end
      end

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Wait for every beat to be offered, taken and answered.
      while (instr_backlog.size() != 0 || req_valid || expected_writebacks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/alurf_pkg.sv
hw/rtl/alurf_front.sv
hw/rtl/alurf_queue.sv
hw/rtl/alurf_back.sv
hw/rtl/alu_register_file_with_flags.sv
tb/alu_register_file_with_flags_tb.sv
